/* hdl/local_wiener_residual_3x3_core_assert.svh */
// Assertion macros used by the checker.
`ifndef LOCAL_WIENER_RESIDUAL_3X3_CORE_ASSERT_SVH
`define LOCAL_WIENER_RESIDUAL_3X3_CORE_ASSERT_SVH

// Clocked implication or plain property, disabled during reset.
`define LWR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define LWR_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/lwr_pkg.sv */
`timescale 1ns / 1ps
package lwr_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LUMA_W    = 12;
    localparam int RES_W     = 17;
    localparam int DIM_W     = 12;
    localparam int NV_W      = 22;
    localparam int ROW_W     = 13;
    // shared divider: numerator and divisor widths
    localparam int DIV_NW    = 44;
    localparam int DIV_DW    = 28;

    // register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_NOISE  = 2'd2;
endpackage

/* hdl/local_wiener_residual_3x3_core.sv */
`timescale 1ns / 1ps
// 3x3 adaptive Wiener noise residual over a raster luma stream.
// Input channel: i_valid / o_stall with i_luma (Q8.4) and i_flush. One beat per
// pixel position; flush beats advance the position to drain the last row.
// Output channel: o_valid / i_stall with o_residual (Q8.8, saturated) and
// o_last_pixel on the final pixel of the frame.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index and
// i_cfg_data; write only while the block is idle.
// Each beat's result is for the pixel one row and one column back, so the
// stream lags by frame_width + 1 beats.
// Per beat, when no result is due: line store read, then write back and window
// shift. A beat with a result steps through accept, read, accumulation of the
// nine window elements through one squaring multiplier, multiply and divider
// setup, two passes through one shared restoring divider (variance, then the
// scaled residual) and the output load. A zero floored variance skips the
// second pass.
// Reset clears the position, window and registers (2048, 2048, 256); the line
// stores are not cleared, rows above the frame are masked out.
// A stalled result waits in the output register; the core finishes the next
// item up to its result and then holds until the register frees.
module local_wiener_residual_3x3_core import lwr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [LUMA_W-1:0]       i_luma,
    input  logic                    i_flush,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [RES_W-1:0] o_residual,
    output logic                    o_last_pixel,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [NV_W-1:0]         i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_MQ   = 4'd3;
    localparam logic [3:0] ST_MS   = 4'd4;
    localparam logic [3:0] ST_D1S  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_V    = 4'd7;
    localparam logic [3:0] ST_MAG  = 4'd8;
    localparam logic [3:0] ST_D2S  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]         r_state;
    logic [DIM_W-1:0]   r_fw, r_fh;
    logic [NV_W-1:0]    r_nv;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // line stores
    logic [LUMA_W-1:0]  mem_a [MAX_WIDTH];
    logic [LUMA_W-1:0]  mem_b [MAX_WIDTH];
    logic [LUMA_W-1:0]  r_rda, r_rdb;

    logic [LUMA_W-1:0]  r_win [3][3];   // [column][row]
    logic [LUMA_W-1:0]  r_x;
    logic [COL_W-1:0]   r_c;
    logic [ROW_W-1:0]   r_r;
    logic               r_left, r_right, r_top, r_bot, r_last;
    logic [1:0]         r_kc, r_kr;
    logic [15:0]        r_s;
    logic [27:0]        r_q;
    logic [3:0]         r_n;
    logic [31:0]        r_nq, r_ss;
    logic signed [17:0] r_d;
    logic [25:0]        r_den;
    logic [38:0]        r_mag;
    logic               r_zero;
    logic               r_phase;
    logic [DIV_NW-1:0]  r_dnum;
    logic [DIV_DW-1:0]  r_rem, r_dden;
    logic [5:0]         r_dcnt;
    logic               r_ov;
    logic signed [RES_W-1:0] r_res;
    logic               r_olast;

    // effective frame size
    logic [DIM_W-1:0] w_eff, h_eff;
    always_comb begin
        if (r_fw == '0) w_eff = DIM_W'(1);
        else if (r_fw > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
        else w_eff = r_fw;
        h_eff = (r_fh == '0) ? DIM_W'(1) : r_fh;
    end

    // wrap of a stale column count onto the next row
    logic             acc_in, wrap;
    logic [COL_W-1:0] c_w;
    logic [ROW_W-1:0] r_w;
    assign acc_in = (r_state == ST_IDLE) && i_valid;
    assign wrap   = ({1'b0, r_col} >= w_eff);
    assign c_w    = wrap ? '0 : r_col;
    assign r_w    = r_row + ROW_W'(wrap);

    // centre position of this beat
    logic [COL_W-1:0]   cc;
    logic signed [13:0] cr;
    logic               hit;
    always_comb begin
        if (r_c == '0) begin
            cc = COL_W'(w_eff - DIM_W'(1));
            cr = $signed({1'b0, r_r}) - 14'sd2;
        end else begin
            cc = r_c - COL_W'(1);
            cr = $signed({1'b0, r_r}) - 14'sd1;
        end
        hit = (cr >= 14'sd0) && (cr < $signed({2'b0, h_eff}));
    end

    // next position
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    always_comb begin
        if (r_r >= ROW_W'({1'b0, h_eff}) + ROW_W'(1)) begin
            n_col = '0;
            n_row = '0;
        end else if ({1'b0, r_c} + DIM_W'(1) >= w_eff) begin
            n_col = '0;
            n_row = r_r + ROW_W'(1);
        end else begin
            n_col = r_c + COL_W'(1);
            n_row = r_r;
        end
    end

    // window element under accumulation
    logic [LUMA_W-1:0] sel;
    logic              in_f;
    logic [23:0]       sq;
    assign sel  = r_win[r_kc][r_kr];
    assign in_f = !(r_kc == 2'd0 && r_left) && !(r_kc == 2'd2 && r_right)
               && !(r_kr == 2'd0 && r_top)  && !(r_kr == 2'd2 && r_bot);
    assign sq   = sel * sel;

    // divider step
    logic [DIV_DW:0] rem_sh;
    logic            ge;
    assign rem_sh = {r_rem, r_dnum[DIV_NW-1]};
    assign ge     = (rem_sh >= {1'b0, r_dden});

    // post-divide math
    logic [21:0]  var_q, v_max;
    logic [16:0]  d_abs;
    logic [16:0]  res_mag;
    assign var_q   = r_dnum[21:0];
    assign v_max   = (var_q < r_nv) ? r_nv : var_q;
    assign d_abs   = r_d[17] ? 17'(-r_d) : r_d[16:0];
    always_comb begin
        if (r_d[17])
            res_mag = (r_dnum > DIV_NW'(65536)) ? 17'h10000 : r_dnum[16:0];
        else
            res_mag = (r_dnum > DIV_NW'(65535)) ? 17'h0FFFF : r_dnum[16:0];
    end

    // line store ports
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_rda <= mem_a[c_w];
            r_rdb <= mem_b[c_w];
        end
        if (r_state == ST_RD) begin
            mem_a[r_c] <= r_x;
            mem_b[r_c] <= r_rda;
        end
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fw    <= DIM_W'(2048);
            r_fh    <= DIM_W'(2048);
            r_nv    <= NV_W'(256);
            r_col   <= '0;
            r_row   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r_win[i][j] <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_fw <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_fh <= i_cfg_data[DIM_W-1:0];
                    CFG_NOISE:  r_nv <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == ST_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_flush ? '0 : i_luma;
                        r_c     <= c_w;
                        r_r     <= r_w;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_col <= n_col;
                    r_row <= n_row;
                    for (int j = 0; j < 3; j++) begin
                        r_win[0][j] <= r_win[1][j];
                        r_win[1][j] <= r_win[2][j];
                    end
                    r_win[2][0] <= r_rdb;
                    r_win[2][1] <= r_rda;
                    r_win[2][2] <= r_x;
                    r_left  <= (cc == '0);
                    r_right <= (cc == COL_W'(w_eff - DIM_W'(1)));
                    r_top   <= (cr == 14'sd0);
                    r_bot   <= (cr == $signed({2'b0, h_eff}) - 14'sd1);
                    r_last  <= (cc == COL_W'(w_eff - DIM_W'(1)))
                            && (cr == $signed({2'b0, h_eff}) - 14'sd1);
                    r_kc <= '0;
                    r_kr <= '0;
                    r_s  <= '0;
                    r_q  <= '0;
                    r_n  <= '0;
                    r_state <= hit ? ST_ACC : ST_IDLE;
                end
                ST_ACC: begin
                    if (in_f) begin
                        r_s <= r_s + 16'(sel);
                        r_q <= r_q + 28'(sq);
                        r_n <= r_n + 4'd1;
                    end
                    if (r_kr == 2'd2) begin
                        r_kr <= '0;
                        r_kc <= r_kc + 2'd1;
                    end else begin
                        r_kr <= r_kr + 2'd1;
                    end
                    if (r_kc == 2'd2 && r_kr == 2'd2) r_state <= ST_MQ;
                end
                ST_MQ: begin
                    r_nq    <= 32'(r_n * r_q);
                    r_d     <= $signed({2'b0, 16'(r_n * r_win[1][1])})
                             - $signed({2'b0, r_s});
                    r_state <= ST_MS;
                end
                ST_MS: begin
                    r_ss    <= r_s * r_s;
                    r_state <= ST_D1S;
                end
                ST_D1S: begin
                    r_dnum  <= DIV_NW'(r_nq - r_ss);
                    r_dden  <= DIV_DW'(r_n * r_n);
                    r_rem   <= '0;
                    r_dcnt  <= 6'(DIV_NW - 1);
                    r_phase <= 1'b0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= ge ? DIV_DW'(rem_sh - {1'b0, r_dden}) : DIV_DW'(rem_sh);
                    r_dnum <= {r_dnum[DIV_NW-2:0], ge};
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == '0) r_state <= r_phase ? ST_OUT : ST_V;
                end
                ST_V: begin
                    r_zero  <= (v_max == '0);
                    r_den   <= 26'(r_n * v_max);
                    r_state <= (v_max == '0) ? ST_OUT : ST_MAG;
                end
                ST_MAG: begin
                    r_mag   <= d_abs * r_nv;
                    r_state <= ST_D2S;
                end
                ST_D2S: begin
                    r_dnum  <= {r_mag, 5'b0} + DIV_NW'(r_den);
                    r_dden  <= DIV_DW'({r_den, 1'b0});
                    r_rem   <= '0;
                    r_dcnt  <= 6'(DIV_NW - 1);
                    r_phase <= 1'b1;
                    r_state <= ST_DIV;
                end
                ST_OUT: begin
                    if (!r_ov || !i_stall) begin
                        if (r_zero) r_res <= '0;
                        else if (r_d[17]) r_res <= -$signed(res_mag);
                        else r_res <= $signed(res_mag);
                        r_olast <= r_last;
                        r_zero  <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_ov;
    assign o_residual   = r_res;
    assign o_last_pixel = r_olast;
    assign o_cfg_ready  = 1'b1;

endmodule

/* hdl/lwr_checker.sv */
`timescale 1ns / 1ps
`include "local_wiener_residual_3x3_core_assert.svh"
module lwr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [11:0] i_luma,
    input logic        i_flush,
    input logic        o_valid,
    input logic        i_stall,
    input logic [16:0] o_residual,
    input logic        o_last_pixel
);
    // a stalled result beat holds
    `LWR_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_residual) && $stable(o_last_pixel), "stalled result changed")
    // a stalled input beat holds
    `LWR_ASSERT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall |=> i_valid && $stable(i_luma) && $stable(i_flush), "stalled input changed")
    // an accepted beat keeps the core busy on the next cycle
    `LWR_ASSERT(a_busy_after_in, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "core not busy after input beat")
    // a new result only comes out of work in progress
    `LWR_NEVER(a_res_from_work, i_clk, i_rst_n, $rose(o_valid) && !$past(o_stall), "result appeared while idle")
endmodule

bind local_wiener_residual_3x3_core lwr_checker u_lwr_checker (.*);
